### src/qmj_pkg.sv
// Shared types and constants for the quintic minimum-jerk interpolator.
// Used by the controller, the datapath and the top level.
package qmj_pkg;

  // Interval count width, set by the num_intervals register.
  localparam int NW = 7;
  // Step time width, unsigned Q0.16.
  localparam int SW = 16;
  // Duration width: NW + SW bits, unsigned.
  localparam int DW = NW + SW;
  // Largest interval count used; larger register values are capped to it.
  localparam int MAX_INTERVALS = 64;
  // Wide accumulator width and its saturation bound.
  localparam int AW = 64;
  localparam logic signed [AW-1:0] WIDE_LIM = 64'sd1 <<< 51;
  // Quotient bits resolved per divider cycle and divider steps per division.
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = AW / DIV_BITS;
  // Joints at or above this index run with zero velocity and acceleration.
  localparam logic [5:0] FIRST_PLAIN_JOINT = 6'd6;

  // Register indexes.
  localparam logic REG_NUM_INTERVALS = 1'b0;
  localparam logic REG_STEP_TIME     = 1'b1;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic          load;      // capture an input item
    logic          dur;       // form the duration
    logic          scale1;    // velocity product and first acceleration product
    logic          scale2;    // second acceleration product
    logic          coef;      // form the six coefficients
    logic          pt_init;   // start Horner for a new point
    logic          mul;       // acc times i
    logic          div_init;  // load the divider
    logic          div_step;  // one divider cycle
    logic          add;       // rounded quotient plus coefficient
    logic          out_load;  // load the output register
    logic          last;      // final point of the run
    logic [NW-1:0] idx;       // point index i
    logic [2:0]    k;         // coefficient number
  } qmj_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [NW-1:0] n_eff;     // effective interval count
    logic          out_free;  // output register can take a point
  } qmj_stat_t;

  // Saturate a wide value to +-WIDE_LIM.
  function automatic logic signed [AW-1:0] clamp_wide(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] r;
    r = a;
    if (a > WIDE_LIM) r = WIDE_LIM;
    if (a < -WIDE_LIM) r = -WIDE_LIM;
    return r;
  endfunction

endpackage

### src/qmj_ctrl.sv
// Sequencer for the quintic interpolator: steps the datapath through setup,
// Horner evaluation with a shared divider, and output of each point.
// Depends on qmj_pkg.
module qmj_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  qmj_pkg::qmj_stat_t stat_i,
  output qmj_pkg::qmj_cmd_t  cmd_o
);
  import qmj_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DUR  = 4'd1;
  localparam logic [3:0] ST_SC1  = 4'd2;
  localparam logic [3:0] ST_SC2  = 4'd3;
  localparam logic [3:0] ST_COEF = 4'd4;
  localparam logic [3:0] ST_PINI = 4'd5;
  localparam logic [3:0] ST_MUL  = 4'd6;
  localparam logic [3:0] ST_DINI = 4'd7;
  localparam logic [3:0] ST_DSTP = 4'd8;
  localparam logic [3:0] ST_ADD  = 4'd9;
  localparam logic [3:0] ST_OUT  = 4'd10;

  logic [3:0]    state_q, state_d;
  logic [NW-1:0] idx_q, idx_d;
  logic [2:0]    k_q, k_d;
  logic [$clog2(DIV_STEPS)-1:0] dcnt_q, dcnt_d;
  logic          last;

  assign in_ready_o = (state_q == ST_IDLE);
  assign last = (idx_q == stat_i.n_eff - NW'(1));

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    k_d     = k_q;
    dcnt_d  = dcnt_q;
    cmd_o   = '0;
    cmd_o.idx  = idx_q;
    cmd_o.k    = k_q;
    cmd_o.last = last;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_DUR;
        end
      end
      ST_DUR: begin
        cmd_o.dur = 1'b1;
        idx_d = NW'(1);
        if (stat_i.n_eff < NW'(2)) state_d = ST_IDLE;
        else state_d = ST_SC1;
      end
      ST_SC1: begin
        cmd_o.scale1 = 1'b1;
        state_d = ST_SC2;
      end
      ST_SC2: begin
        cmd_o.scale2 = 1'b1;
        state_d = ST_COEF;
      end
      ST_COEF: begin
        cmd_o.coef = 1'b1;
        state_d = ST_PINI;
      end
      ST_PINI: begin
        cmd_o.pt_init = 1'b1;
        k_d = 3'd4;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = ST_DINI;
      end
      ST_DINI: begin
        cmd_o.div_init = 1'b1;
        dcnt_d = '0;
        state_d = ST_DSTP;
      end
      ST_DSTP: begin
        cmd_o.div_step = 1'b1;
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == ($clog2(DIV_STEPS))'(DIV_STEPS - 1)) state_d = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        if (k_q == 3'd0) begin
          state_d = ST_OUT;
        end else begin
          k_d = k_q - 3'd1;
          state_d = ST_MUL;
        end
      end
      ST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + NW'(1);
            state_d = ST_PINI;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      k_q     <= '0;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      k_q     <= k_d;
      dcnt_q  <= dcnt_d;
    end
  end

endmodule

### src/qmj_datapath.sv
// Datapath of the quintic interpolator: duration scaling, coefficients,
// Horner evaluation with a digit-serial divider, and the output register.
// Depends on qmj_pkg.
module qmj_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qmj_pkg::qmj_cmd_t  cmd_i,
  output qmj_pkg::qmj_stat_t stat_o,
  input  logic [5:0]         joint_i,
  input  logic [31:0]        first_pos_i,
  input  logic [31:0]        end_pos_i,
  input  logic [31:0]        first_vel_i,
  input  logic [31:0]        start_acc_i,
  input  logic [qmj_pkg::NW-1:0] num_intervals_i,
  input  logic [qmj_pkg::SW-1:0] step_time_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [5:0]         out_joint_o,
  output logic [5:0]         out_index_o,
  output logic [31:0]        out_pos_o,
  output logic               out_last_o
);
  import qmj_pkg::*;

  logic [5:0]            joint_q;
  logic signed [31:0]    x0_q, x1_q, v_q, a_q;
  logic [NW-1:0]         n_q;
  logic [SW-1:0]         st_q;
  logic [DW-1:0]         d_q;
  logic signed [39:0]    vs_q, t1_q;
  logic signed [47:0]    as_q;
  logic signed [AW-1:0]  e_q [6];
  logic signed [AW-1:0]  acc_q, prod_q;
  logic [AW-1:0]         dq_q;
  logic [8:0]            rem_q;
  logic                  neg_q;
  logic                  ovalid_q, ovalid_d;
  logic [5:0]            ojoint_q;
  logic [5:0]            oidx_q;
  logic [31:0]           opos_q;
  logic                  olast_q;

  logic [NW-1:0]         n_in;
  logic                  plain;
  logic signed [55:0]    vprod, aprod;
  logic signed [23:0]    t1_hi;
  logic signed [47:0]    qd;
  logic [38:0]           rd;
  logic signed [60:0]    prod_n;
  logic signed [AW-1:0]  x0w, x1w, vsw, asw;
  logic signed [AW-1:0]  num, mag;
  logic [AW-1:0]         dq_n;
  logic [8:0]            rem_n;
  logic [8:0]            den;
  logic signed [AW-1:0]  qs;
  logic signed [AW-1:0]  pos_w;
  logic [31:0]           pos_sat;

  // Effective interval count, capped at the configured maximum.
  assign n_in = (int'(num_intervals_i) > MAX_INTERVALS) ? NW'(MAX_INTERVALS)
                                                        : num_intervals_i;
  assign plain = (joint_i >= FIRST_PLAIN_JOINT);
  assign stat_o.n_eff = n_q;
  assign stat_o.out_free = !ovalid_q || out_ready_i;

  // Duration products.
  assign vprod = v_q * $signed({1'b0, d_q});
  assign aprod = a_q * $signed({1'b0, d_q});
  assign t1_hi = 24'(t1_q >>> 16);
  assign qd    = t1_hi * $signed({1'b0, d_q});
  assign rd    = t1_q[15:0] * d_q;

  // Horner product acc times i.
  assign prod_n = $signed(acc_q[52:0]) * $signed({1'b0, cmd_i.idx});

  // Sign-extended operands for the coefficients.
  assign x0w = AW'(x0_q);
  assign x1w = AW'(x1_q);
  assign vsw = AW'(vs_q);
  assign asw = AW'(as_q);

  // Rounded division numerator 2*acc*i + n, split into sign and magnitude.
  assign num = (prod_q <<< 1) + AW'($signed({1'b0, n_q}));
  assign mag = num[AW-1] ? -num : num;
  assign den = {1'b0, n_q, 1'b0};

  // Eight quotient bits per cycle against the narrow divisor 2n.
  always_comb begin
    logic [8:0]    r;
    logic [AW-1:0] q;
    r = rem_q;
    q = dq_q;
    for (int b = 0; b < DIV_BITS; b++) begin
      r = {r[7:0], q[AW-1]};
      q = {q[AW-2:0], 1'b0};
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    rem_n = r;
    dq_n  = q;
  end

  // Floor quotient: negative numerators round away when a remainder is left.
  assign qs = neg_q ? (-$signed(dq_q) - AW'($signed({1'b0, (rem_q != 9'd0)})))
                    : $signed(dq_q);

  // Halve with rounding up and saturate to 32 bits.
  assign pos_w = (acc_q + AW'(1)) >>> 1;
  assign pos_sat = (pos_w > AW'(64'sd2147483647)) ? 32'h7fff_ffff :
                   (pos_w < -AW'(64'sd2147483648)) ? 32'h8000_0000 : pos_w[31:0];

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      joint_q <= joint_i;
      x0_q    <= $signed(first_pos_i);
      x1_q    <= $signed(end_pos_i);
      v_q     <= plain ? 32'sd0 : $signed(first_vel_i);
      a_q     <= plain ? 32'sd0 : $signed(start_acc_i);
      n_q     <= n_in;
      st_q    <= step_time_i;
    end
    if (cmd_i.dur) d_q <= DW'(n_q) * DW'(st_q);
    if (cmd_i.scale1) begin
      vs_q <= 40'(vprod >>> 16);
      t1_q <= 40'(aprod >>> 16);
    end
    if (cmd_i.scale2) as_q <= qd + 48'($signed({1'b0, rd[38:16]}));
    if (cmd_i.coef) begin
      e_q[0] <= clamp_wide(x0w <<< 1);
      e_q[1] <= clamp_wide(vsw <<< 1);
      e_q[2] <= clamp_wide(asw);
      e_q[3] <= clamp_wide(-asw * 64'sd3 - vsw * 64'sd12 - x0w * 64'sd20 + x1w * 64'sd20);
      e_q[4] <= clamp_wide(asw * 64'sd3 + vsw * 64'sd16 + x0w * 64'sd30 - x1w * 64'sd30);
      e_q[5] <= clamp_wide(-asw - vsw * 64'sd6 - x0w * 64'sd12 + x1w * 64'sd12);
    end
    if (cmd_i.pt_init) acc_q <= e_q[5];
    else if (cmd_i.add) acc_q <= clamp_wide(qs + e_q[cmd_i.k]);
    if (cmd_i.mul) prod_q <= AW'(prod_n);
    if (cmd_i.div_init) begin
      dq_q  <= mag;
      rem_q <= '0;
      neg_q <= num[AW-1];
    end else if (cmd_i.div_step) begin
      dq_q  <= dq_n;
      rem_q <= rem_n;
    end
    if (cmd_i.out_load) begin
      ojoint_q <= joint_q;
      oidx_q   <= 6'(cmd_i.idx);
      opos_q   <= pos_sat;
      olast_q  <= cmd_i.last;
    end
  end

  // Output valid flag.
  always_comb begin
    ovalid_d = ovalid_q;
    if (out_ready_i) ovalid_d = 1'b0;
    if (cmd_i.out_load) ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else ovalid_q <= ovalid_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_joint_o = ojoint_q;
  assign out_index_o = oidx_q;
  assign out_pos_o   = opos_q;
  assign out_last_o  = olast_q;

endmodule

### src/quintic_min_jerk_interpolator.sv
// Top level of the quintic minimum-jerk interpolator: APB registers and the
// stream ports around qmj_ctrl and qmj_datapath. Depends on qmj_pkg.
//
//  Channel  | Direction | Content
//  s_axis   | in        | one segment item
//  m_axis   | out       | one interior point item, tlast on the final one
//  apb      | in/out    | num_intervals at 0x0, step_time at 0x4
//
// An item is accepted in the idle state, then passes the setup states for
// duration, scaling and coefficients. Each interior point takes a Horner
// start, five Horner steps of multiply, divider load, divider steps and add,
// and an output step; the shared digit-serial divider does most of the work.
// Items are taken only when no segment is in progress; a stalled output
// holds the sequencer in its output cycle. Reset is asynchronous, active low.
module quintic_min_jerk_interpolator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // joint_number[5:0], initial position[37:6], end_pos[69:38],
  // initial velocity[101:70], start_acc[133:102], zero padding
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // joint_echo[5:0], step number[11:6], position[43:12], zero padding
  output logic [47:0]  m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import qmj_pkg::*;

  logic [NW-1:0] num_intervals_q;
  logic [SW-1:0] step_time_q;
  qmj_cmd_t      cmd;
  qmj_stat_t     stat;
  logic [5:0]    oj, oi;
  logic [31:0]   op;

  // Configuration registers.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_intervals_q <= NW'(16);
      step_time_q     <= SW'(3277);
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_NUM_INTERVALS: num_intervals_q <= pwdata[NW-1:0];
        REG_STEP_TIME:     step_time_q     <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (paddr[2])
      REG_NUM_INTERVALS: prdata = 32'(num_intervals_q);
      REG_STEP_TIME:     prdata = 32'(step_time_q);
      default:           prdata = '0;
    endcase
  end

  qmj_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  qmj_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .joint_i         (s_axis_tdata[5:0]),
    .first_pos_i     (s_axis_tdata[37:6]),
    .end_pos_i       (s_axis_tdata[69:38]),
    .first_vel_i     (s_axis_tdata[101:70]),
    .start_acc_i     (s_axis_tdata[133:102]),
    .num_intervals_i (num_intervals_q),
    .step_time_i     (step_time_q),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_joint_o     (oj),
    .out_index_o     (oi),
    .out_pos_o       (op),
    .out_last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0, op, oi, oj};

endmodule

### tb/testbench.sv
// Self-checking testbench for the quintic minimum-jerk interpolator.
// Drives segment items and APB register writes, predicts every point item.
// Depends on qmj_pkg and quintic_min_jerk_interpolator.
module testbench;
  import qmj_pkg::*;

  localparam int MAX_N = 64;
  localparam logic signed [63:0] LIM = 64'sd1 <<< 51;

  typedef struct packed {
    logic [5:0]         joint;
    logic signed [31:0] x0;
    logic signed [31:0] x1;
    logic signed [31:0] vel;
    logic signed [31:0] acc;
  } segment_t;

  typedef struct packed {
    logic [5:0]         joint;
    logic [5:0]         idx;
    logic signed [31:0] pos;
    logic               last;
  } point_t;

  // Directed row: the segment, plus an optional typed-in position for every point.
  typedef struct {
    segment_t seg;
    bit       has_pos;
    logic signed [31:0] pos;
  } row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // joint_number, initial position, end_pos, initial velocity, start_acc, zero padding
  logic [135:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // joint_echo, step number, position, zero padding
  logic [47:0]  m_axis_tdata;
  logic         m_axis_tlast;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  quintic_min_jerk_interpolator DUT (.*);

  always #5 clk_i = ~clk_i;

  // Local copies of the registers and the queue of predicted points.
  logic [6:0]  intervals_q = 7'd16;
  logic [15:0] step_q = 16'd3277;
  point_t      points_q[$];
  logic signed [31:0] fixed_pos_q[$];
  bit          fixed_valid_q[$];
  int          errors = 0;
  int          stall_left = 0;
  bit          out_quiet = 1'b0;

  function automatic logic signed [63:0] sat51(input logic signed [63:0] a);
    if (a > LIM) return LIM;
    if (a < -LIM) return -LIM;
    return a;
  endfunction

  function automatic logic signed [63:0] floor16(input logic signed [63:0] a);
    return a >>> 16;
  endfunction

  // Round to nearest, ties upward: floor((2a + n) / 2n).
  function automatic logic signed [63:0] rnd_div(input logic signed [63:0] a,
                                                  input logic signed [63:0] n);
    logic signed [63:0] num, den, q;
    num = 2 * a + n;
    den = 2 * n;
    q = num / den;
    if ((num % den) < 0) q = q - 1;
    return q;
  endfunction

  // Expand one segment into its interior trajectory points.
  task automatic predict_points(input segment_t s, input bit has_pos,
                                input logic signed [31:0] pos_fix);
    logic signed [63:0] n, d, x0, x1, v, a, vs, t1, q, r, as_, acc, p;
    logic signed [63:0] e[6];
    point_t pt;
    n = intervals_q > MAX_N ? MAX_N : intervals_q;
    if (n < 2) return;
    x0 = s.x0; x1 = s.x1; v = s.vel; a = s.acc;
    if (s.joint >= FIRST_PLAIN_JOINT) begin
      v = 0; a = 0;
    end
    d = n * $signed({48'd0, step_q});
    vs = floor16(v * d);
    t1 = floor16(a * d);
    q = floor16(t1);
    r = t1 - q * 65536;
    as_ = q * d + ((r * d) >>> 16);
    e[0] = sat51(2 * x0);
    e[1] = sat51(2 * vs);
    e[2] = sat51(as_);
    e[3] = sat51(-3 * as_ - 12 * vs - 20 * x0 + 20 * x1);
    e[4] = sat51(3 * as_ + 16 * vs + 30 * x0 - 30 * x1);
    e[5] = sat51(-as_ - 6 * vs - 12 * x0 + 12 * x1);
    for (int i = 1; i < n; i++) begin
      acc = e[5];
      for (int k = 4; k >= 0; k--) acc = sat51(rnd_div(acc * i, n) + e[k]);
      p = floor16((acc + 1) * 32768);
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      pt.joint = s.joint;
      pt.idx = i[5:0];
      pt.pos = p[31:0];
      pt.last = (i == n - 1);
      points_q = {points_q, pt};
      fixed_valid_q = {fixed_valid_q, has_pos};
      fixed_pos_q = {fixed_pos_q, pos_fix};
    end
  endtask

  // Register write: APB setup and access phases, then an idle gap.
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 3'd0) intervals_q = val[6:0];
    else if (addr == 3'd4) step_q = val[15:0];
    @(posedge clk_i);
  endtask

  // Send one segment, with an optional random gap before it.
  task automatic send_segment(input segment_t s, input bit has_pos,
                              input logic signed [31:0] pos_fix, input bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    predict_points(s, has_pos, pos_fix);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, s.acc, s.vel, s.x1, s.x0, s.joint};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_points();
    s_axis_tvalid <= 1'b0;
    while (points_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic segment_t rand_segment(input bit narrow);
    segment_t s;
    s.joint = $urandom_range(0, 63);
    if ($urandom_range(0, 1)) s.joint = $urandom_range(0, 7);
    s.x0 = $urandom; s.x1 = $urandom; s.vel = $urandom; s.acc = $urandom;
    if (narrow) begin
      s.x0 = $signed(s.x0) >>> $urandom_range(0, 12);
      s.x1 = $signed(s.x1) >>> $urandom_range(0, 12);
      s.vel = $signed(s.vel) >>> $urandom_range(4, 20);
      s.acc = $signed(s.acc) >>> $urandom_range(4, 20);
    end
    return s;
  endfunction

  // Output side: random backpressure in bursts, compare each point.
  always @(posedge clk_i) begin
    point_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[5:0], m_axis_tdata[11:6], m_axis_tdata[43:12], m_axis_tlast};
      if (points_q.size() == 0) begin
        $display("%0t unexpected point: expected none, actual %p", $time, got);
        errors++;
      end else begin
        want = points_q.pop_front();
        if (fixed_valid_q.pop_front()) want.pos = fixed_pos_q.pop_front();
        else void'(fixed_pos_q.pop_front());
        if (got !== want) begin
          $display("%0t point mismatch: expected %p, actual %p", $time, want, got);
          errors++;
        end
      end
    end
    if (!rst_ni || out_quiet) begin
      stall_left = 0;
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    #60000000;
    $display("quintic_min_jerk_interpolator: mismatch");
    $finish;
  end

  initial begin
    row_t rows[$];
    row_t rw;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset settings: flat segments give flat points; the other rows are predicted.
    rw.has_pos = 1; rw.seg = '{6'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}; rw.pos = 0;
    rows = {rows, rw};
    rw.seg = '{6'd63, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
    rw.pos = 32'sh7fffffff; rows = {rows, rw};
    rw.seg = '{6'd6, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000};
    rw.pos = 32'sh80000000; rows = {rows, rw};
    rw.has_pos = 0;
    rw.seg = '{6'd5, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
    rows = {rows, rw};
    rw.seg = '{6'd0, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh80000000};
    rows = {rows, rw};
    rw.seg = '{6'd7, 32'sh0, 32'sh10000, 32'sh20000, 32'sh30000}; rows = {rows, rw};
    rw.seg = '{6'd2, 32'sh0, 32'sh10000, 32'sh20000, 32'sh30000}; rows = {rows, rw};
    foreach (rows[j]) send_segment(rows[j].seg, rows[j].has_pos, rows[j].pos, 0);
    drain_points();

    // Extremes of the registers, including too few and too many intervals.
    reg_write(3'd0, 32'd2); reg_write(3'd4, 32'd65535);
    send_segment(rand_segment(0), 0, 0, 0);
    send_segment('{6'd1, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000},
                 0, 0, 0);
    drain_points();
    reg_write(3'd4, 32'd0);
    send_segment(rand_segment(0), 0, 0, 0);
    drain_points();
    reg_write(3'd0, 32'd127); reg_write(3'd4, 32'd1);
    send_segment(rand_segment(0), 0, 0, 0);
    drain_points();
    reg_write(3'd0, 32'd64); reg_write(3'd4, 32'hffff_ffff);
    send_segment(rand_segment(0), 0, 0, 0);
    drain_points();
    reg_write(3'd0, 32'd1);
    send_segment(rand_segment(0), 0, 0, 0);
    send_segment(rand_segment(0), 0, 0, 0);
    drain_points();
    reg_write(3'd0, 32'd0);
    send_segment(rand_segment(0), 0, 0, 0);
    drain_points();
    reg_write(3'd0, 32'd3);
    reg_write(3'd4, 32'd40000);
    send_segment(rand_segment(1), 0, 0, 0);
    drain_points();

    // Random phases: mostly small interval counts, a few large.
    for (int ph = 0; ph < 10; ph++) begin
      if (ph % 4 == 3) reg_write(3'd0, $urandom_range(32, 80));
      else reg_write(3'd0, $urandom_range(2, 8));
      reg_write(3'd4, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 8000));
      if (ph == 9) out_quiet = 1'b1;
      for (int j = 0; j < 21; j++) send_segment(rand_segment($urandom_range(0, 2) != 0),
                                                0, 0, ph != 9);
      drain_points();
    end

    if (errors == 0) $display("quintic_min_jerk_interpolator: match");
    else $display("quintic_min_jerk_interpolator: mismatch");
    $finish;
  end

endmodule

### sim.f
src/qmj_pkg.sv
src/qmj_ctrl.sv
src/qmj_datapath.sv
src/quintic_min_jerk_interpolator.sv
tb/testbench.sv
